@@ src/u16u8_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and byte encoding functions for the UTF-16 to UTF-8 transcoder.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package u16u8_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] SURR_HIGH_LO = 16'hD800;
	localparam logic [15:0] SURR_LOW_LO  = 16'hDC00;
	localparam logic [15:0] SURR_END     = 16'hE000;
	localparam logic [20:0] SUPP_BASE    = 21'h10000;
	localparam logic [5:0]  HIGH_PREFIX  = 6'b110110;

	// Sequence length codes (byte count minus one)
	localparam logic [1:0] LEN1 = 2'd0;
	localparam logic [1:0] LEN2 = 2'd1;
	localparam logic [1:0] LEN3 = 2'd2;
	localparam logic [1:0] LEN4 = 2'd3;

	// Work for the back end: an optional lone high surrogate (3 bytes), then
	// an optional code point of 1 to 4 bytes.
	typedef struct packed {
		logic        has_lone;
		logic [9:0]  lone_bits;
		logic        has_main;
		logic [20:0] main_cp;
	} job_t;

	function automatic logic [1:0] cp_len(input logic [20:0] cp);
		logic [1:0] len;
		if (cp < 21'h80)
			len = LEN1;
		else if (cp < 21'h800)
			len = LEN2;
		else if (cp < SUPP_BASE)
			len = LEN3;
		else
			len = LEN4;
		return len;
	endfunction

	function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] len,
	                                        input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (len)
			LEN1: b = cp[7:0];
			LEN2: begin
				if (idx == 2'd0)
					b = {3'b110, cp[10:6]};
				else
					b = {2'b10, cp[5:0]};
			end
			LEN3: begin
				unique case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				unique case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

@@ src/u16u8_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts UTF-16 code units, pairs surrogates and pushes encoding jobs.
// Depends on u16u8_pkg.
module u16u8_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        code_unit,
	input  logic               end_of_text,
	input  logic               q_full,
	output logic               push,
	output u16u8_pkg::job_t    push_job
);
	import u16u8_pkg::*;

	logic [9:0] held_q;
	logic       held_valid_q;
	logic       is_high;
	logic       is_low;
	logic       accept;
	logic       hold_new;
	job_t       job;

	assign is_high  = (code_unit >= SURR_HIGH_LO) && (code_unit < SURR_LOW_LO);
	assign is_low   = (code_unit >= SURR_LOW_LO) && (code_unit < SURR_END);
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign hold_new = is_high && !end_of_text && !(held_valid_q && is_low);

	always_comb begin
		job           = '0;
		job.lone_bits = held_q;
		if (held_valid_q && is_low) begin
			job.has_main = 1'b1;
			job.main_cp  = SUPP_BASE + {1'b0, held_q, code_unit[9:0]};
		end else begin
			job.has_lone = held_valid_q;
			job.has_main = !hold_new;
			job.main_cp  = {5'd0, code_unit};
		end
	end

	assign push     = accept && (job.has_lone || job.has_main);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			held_valid_q <= hold_new;
			held_q       <= hold_new ? code_unit[9:0] : 10'd0;
		end
	end

endmodule

@@ src/u16u8_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between the front and back ends, built from flip-flops.
// Depends on u16u8_pkg.
module u16u8_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  u16u8_pkg::job_t    push_job,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output u16u8_pkg::job_t    head
);
	import u16u8_pkg::*;

	job_t                ent_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full  = count_q == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ src/u16u8_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the head job byte by byte into a registered output stage.
// Depends on u16u8_pkg.
module u16u8_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  u16u8_pkg::job_t    head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_of_run
);
	import u16u8_pkg::*;

	logic        phase_q;
	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        seg_lone;
	logic [20:0] cp;
	logic [1:0]  len;
	logic        seg_end;
	logic        job_last;
	logic        step;

	// The lone high surrogate goes first, when the job has one
	assign seg_lone = !phase_q && head.has_lone;
	assign cp       = seg_lone ? {5'd0, HIGH_PREFIX, head.lone_bits} : head.main_cp;
	assign len      = seg_lone ? LEN3 : cp_len(cp);
	assign seg_end  = idx_q == len;
	assign job_last = seg_end && (!seg_lone || !head.has_main);
	assign step     = !empty && (!out_valid_q || out_ready);
	assign pop      = step && job_last;

	always_ff @(posedge clk) begin
		if (step) begin
			byte_q <= enc_byte(cp, len, idx_q);
			last_q <= job_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (step) begin
				if (job_last) begin
					phase_q <= 1'b0;
					idx_q   <= '0;
				end else if (seg_end) begin
					phase_q <= 1'b1;
					idx_q   <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

endmodule

@@ src/utf16_to_utf8_transcoder.sv @@
`timescale 1ns / 1ps
// UTF-16 to UTF-8 (WTF-8) transcoder top level: front end, job queue, back end.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.

// One UTF-16 code unit enters per request on the s_ side, with s_tlast marking
// the end of the text; surrogate pairs become 4-byte sequences and unpaired
// surrogates 3-byte sequences. Bytes leave one per cycle on the m_ side while
// m_tready is high, m_tlast set on the final byte caused by each input unit. A
// unit that completes a pair or stands alone gives 1 to 4 bytes, one that
// flushes a held surrogate up to 6; a held high surrogate gives no bytes. The
// single byte output lane sets the sustained rate. A 4-entry job queue lets
// the input run ahead while output is stalled.
module utf16_to_utf8_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] code_unit
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast    // last_of_run
);
	import u16u8_pkg::*;

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	job_t push_job;
	job_t head;

	u16u8_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.code_unit   (s_tdata),
		.end_of_text (s_tlast),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job)
	);

	u16u8_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	u16u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (q_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.last_of_run (m_tlast)
	);

endmodule
